// ===== src/sas_pkg.sv =====
// ----------------------------------------------------------------------------
// Slab slot allocator package
// Shared codes, field widths and the control bundle of the block queue.
// ----------------------------------------------------------------------------
package sas_pkg;

    localparam int MODE_W   = 1;
    localparam int FBLK_W   = 4;
    localparam int FSLOT_W  = 6;
    localparam int STATUS_W = 2;
    localparam int FTOT_W   = 11;
    localparam int SPB_W    = 7;
    localparam int MINB_W   = 5;
    localparam int CIDX_W   = 2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD       = 2'd2;

    localparam logic [MODE_W-1:0] MODE_ALLOC = 1'b0;
    localparam logic [MODE_W-1:0] MODE_FREE  = 1'b1;

    localparam logic [CIDX_W-1:0] CFG_SPB  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_MINB = 2'd1;

    localparam int RST_SPB  = 64;
    localparam int RST_MINB = 1;

    typedef struct packed {
        logic init;
        logic push;
        logic remove;
    } sas_qctl_t;

endpackage

// ===== src/sas_cell.sv =====
// ----------------------------------------------------------------------------
// Queue cell
// Holds one entry of the ordered block queue and shifts left on removal.
// ----------------------------------------------------------------------------
module sas_cell
    import sas_pkg::*;
#(
    parameter int MAX_BLOCKS = 16,
    parameter int IDX        = 0
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  sas_qctl_t                               ctl,
    input  logic [((MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1)-1:0] key,
    input  logic [((MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1)-1:0] push_val,
    input  logic [$clog2(MAX_BLOCKS + 1)-1:0]       len,
    input  logic [((MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1)-1:0] right_val,
    input  logic                                    hit_in,
    output logic                                    hit_out,
    output logic [((MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1)-1:0] value
);

    localparam int BW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int LW = $clog2(MAX_BLOCKS + 1);

    logic [BW-1:0] value_reg;
    logic [BW-1:0] value_next;
    logic          in_use;
    logic          match;

    assign in_use  = LW'(IDX) < len;
    assign match   = ctl.remove && in_use && (value_reg == key);
    assign hit_out = hit_in | match;
    assign value   = value_reg;

    always_comb
    begin
        value_next = value_reg;
        if (ctl.init)
        begin
            value_next = BW'(IDX);
        end
        else if (ctl.remove && in_use && hit_out)
        begin
            value_next = right_val;
        end
        else if (ctl.push && (LW'(IDX) == len))
        begin
            value_next = push_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= BW'(IDX);
        end
        else
        begin
            value_reg <= value_next;
        end
    end

endmodule

// ===== src/sas_queue.sv =====
// ----------------------------------------------------------------------------
// Available-block queue
// A row of cells with a length register; push at the tail, remove by key.
// ----------------------------------------------------------------------------
module sas_queue
    import sas_pkg::*;
#(
    parameter int MAX_BLOCKS = 16,
    parameter int INIT_LEN   = 1
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  sas_qctl_t                               ctl,
    input  logic [((MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1)-1:0] key,
    input  logic [((MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1)-1:0] push_val,
    input  logic [$clog2(MAX_BLOCKS + 1)-1:0]       init_len,
    output logic [((MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1)-1:0] head,
    output logic [$clog2(MAX_BLOCKS + 1)-1:0]       len
);

    localparam int BW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int LW = $clog2(MAX_BLOCKS + 1);

    logic [BW-1:0] vals [MAX_BLOCKS];
    logic          hits [MAX_BLOCKS+1];
    logic [LW-1:0] len_reg;

    assign hits[0] = 1'b0;
    assign head    = vals[0];
    assign len     = len_reg;

    for (genvar i = 0; i < MAX_BLOCKS; i++)
    begin : g_cell
        logic [BW-1:0] right;
        if (i == MAX_BLOCKS - 1)
        begin : g_last
            assign right = vals[i];
        end
        else
        begin : g_mid
            assign right = vals[i+1];
        end
        sas_cell #(
            .MAX_BLOCKS (MAX_BLOCKS),
            .IDX        (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .key       (key),
            .push_val  (push_val),
            .len       (len_reg),
            .right_val (right),
            .hit_in    (hits[i]),
            .hit_out   (hits[i+1]),
            .value     (vals[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= LW'(INIT_LEN);
        end
        else if (ctl.init)
        begin
            len_reg <= init_len;
        end
        else if (ctl.remove)
        begin
            if (hits[MAX_BLOCKS])
            begin
                len_reg <= len_reg - LW'(1);
            end
        end
        else if (ctl.push && (32'(len_reg) < MAX_BLOCKS))
        begin
            len_reg <= len_reg + LW'(1);
        end
    end

endmodule

// ===== src/slab_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// Slab slot allocator
// Hands out and takes back slots of a pool of blocks with per-block stacks.
// ----------------------------------------------------------------------------
// One request is handled at a time by a small sequencer. An allocate runs the
// take, finish and output steps, after a grow step when an idle block must go
// live; a free runs the check and output steps, with a release step between
// when it releases its block. The steps sit around the registered read of the
// slot stack memory and the shift of the block queue cells. A finished result
// waits in an output register while the next request is accepted.
module slab_slot_allocator
    import sas_pkg::*;
#(
    parameter int MAX_BLOCKS = 16,
    parameter int MAX_SLOTS  = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [MODE_W-1:0]    mode,
    input  logic [FBLK_W-1:0]    free_block,
    input  logic [FSLOT_W-1:0]   free_slot,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [STATUS_W-1:0]  status,
    output logic [FBLK_W-1:0]    got_block,
    output logic [FSLOT_W-1:0]   got_slot,
    output logic                 block_released,
    output logic [FTOT_W-1:0]    free_total,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CIDX_W-1:0]    cfg_index,
    input  logic [SPB_W-1:0]     cfg_data
);

    localparam int BW   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int SW   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int LW   = $clog2(MAX_BLOCKS + 1);
    localparam int CW   = $clog2(MAX_SLOTS + 1);
    localparam int FW   = $clog2(MAX_BLOCKS * 128 + 1);
    localparam int DEP  = MAX_BLOCKS * MAX_SLOTS;
    localparam int AW   = (DEP > 1) ? $clog2(DEP) : 1;
    localparam int R_SPB  = (RST_SPB > MAX_SLOTS) ? MAX_SLOTS : RST_SPB;
    localparam int R_MINB = (RST_MINB > MAX_BLOCKS) ? MAX_BLOCKS : RST_MINB;

    typedef enum logic [2:0] {
        S_IDLE,
        S_A_GROW,
        S_A_TAKE,
        S_A_FIN,
        S_F_CHK,
        S_F_REL,
        S_OUT
    } state_t;

    state_t                  state_reg;
    logic [SPB_W-1:0]        spb_reg;
    logic [MINB_W-1:0]       minb_reg;
    logic [MAX_BLOCKS-1:0]   live_reg;
    logic [CW-1:0]           used_reg [MAX_BLOCKS];
    logic [CW-1:0]           fill_reg [MAX_BLOCKS];
    logic [LW-1:0]           live_cnt_reg;
    logic [FW-1:0]           free_reg;
    logic [FBLK_W-1:0]       fblk_reg;
    logic [FSLOT_W-1:0]      fslot_reg;
    logic [SW-1:0]           u_reg;
    logic                    byp_reg;
    logic                    full_reg;
    logic [STATUS_W-1:0]     res_status_reg;
    logic [BW-1:0]           res_blk_reg;
    logic [SW-1:0]           res_slot_reg;
    logic                    res_rel_reg;
    logic                    out_valid_reg;
    logic [STATUS_W-1:0]     out_status_reg;
    logic [FBLK_W-1:0]       out_blk_reg;
    logic [FSLOT_W-1:0]      out_slot_reg;
    logic                    out_rel_reg;
    logic [FTOT_W-1:0]       out_ftot_reg;

    logic [SW-1:0]           slot_mem [DEP];
    logic [SW-1:0]           rd_q;
    logic                    mem_we;
    logic [AW-1:0]           mem_addr;
    logic [SW-1:0]           mem_wdata;

    sas_qctl_t               qctl;
    logic [BW-1:0]           q_key;
    logic [BW-1:0]           q_push_val;
    logic [LW-1:0]           q_init_len;
    logic [BW-1:0]           q_head;
    logic [LW-1:0]           q_len;

    logic                    cfg_fire;
    logic                    in_fire;
    logic                    out_free;
    logic [SPB_W-1:0]        spb_new;
    logic [MINB_W-1:0]       minb_new;
    logic [BW-1:0]           blk_sel;
    logic [CW-1:0]           used_sel;
    logic [CW-1:0]           fill_sel;
    logic [CW-1:0]           u_take;
    logic                    idle_found;
    logic [BW-1:0]           idle_blk;
    logic                    free_bad;
    logic [CW-1:0]           used_dec;
    logic [FW-1:0]           free_inc;
    logic                    rel_cond;

    assign cfg_ready      = (state_reg == S_IDLE);
    assign cfg_fire       = cfg_valid && cfg_ready;
    assign in_stall       = (state_reg != S_IDLE) || cfg_valid;
    assign in_fire        = in_valid && !in_stall;
    assign out_free       = !out_valid_reg || !out_stall;
    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign got_block      = out_blk_reg;
    assign got_slot       = out_slot_reg;
    assign block_released = out_rel_reg;
    assign free_total     = out_ftot_reg;

    always_comb
    begin
        spb_new  = spb_reg;
        minb_new = minb_reg;
        if (cfg_index == CFG_SPB)
        begin
            if (cfg_data == '0)
            begin
                spb_new = SPB_W'(1);
            end
            else if (32'(cfg_data) > MAX_SLOTS)
            begin
                spb_new = SPB_W'(MAX_SLOTS);
            end
            else
            begin
                spb_new = cfg_data;
            end
        end
        else if (cfg_index == CFG_MINB)
        begin
            if (32'(cfg_data[MINB_W-1:0]) > MAX_BLOCKS)
            begin
                minb_new = MINB_W'(MAX_BLOCKS);
            end
            else
            begin
                minb_new = cfg_data[MINB_W-1:0];
            end
        end
    end

    always_comb
    begin
        idle_found = 1'b0;
        idle_blk   = '0;
        for (int i = MAX_BLOCKS - 1; i >= 0; i--)
        begin
            if (!live_reg[i])
            begin
                idle_found = 1'b1;
                idle_blk   = BW'(i);
            end
        end
    end

    always_comb
    begin
        blk_sel  = (state_reg == S_A_TAKE) ? q_head : BW'(fblk_reg);
        used_sel = used_reg[blk_sel];
        fill_sel = fill_reg[blk_sel];
        u_take   = (32'(used_sel) >= MAX_SLOTS) ? CW'(MAX_SLOTS - 1) : used_sel;
        used_dec = used_sel - CW'(1);
        free_inc = free_reg + FW'(1);
        free_bad = (32'(fblk_reg) >= MAX_BLOCKS) || !live_reg[blk_sel]
                   || (used_sel == '0) || (32'(fslot_reg) >= 32'(spb_reg));
        rel_cond = (used_dec == '0) && (32'(live_cnt_reg) > 32'(minb_reg))
                   && (32'(free_inc) > 32'(spb_reg))
                   && ((32'(free_inc) - 32'(spb_reg)) > (32'(spb_reg >> 1) + 32'd1));
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_addr  = AW'(32'(blk_sel) * MAX_SLOTS + 32'(u_take));
        mem_wdata = SW'(u_take);
        if (state_reg == S_A_TAKE)
        begin
            mem_we = (u_take == fill_sel);
        end
        else if ((state_reg == S_F_CHK) && !free_bad)
        begin
            mem_we    = 1'b1;
            mem_addr  = AW'(32'(blk_sel) * MAX_SLOTS + 32'(used_dec));
            mem_wdata = SW'(fslot_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_addr] <= mem_wdata;
        end
        rd_q <= slot_mem[mem_addr];
    end

    always_comb
    begin
        qctl        = '0;
        q_key       = res_blk_reg;
        q_push_val  = idle_blk;
        q_init_len  = LW'(minb_new);
        qctl.init   = cfg_fire && ((cfg_index == CFG_SPB) || (cfg_index == CFG_MINB));
        unique case (state_reg)
            S_A_GROW:
            begin
                qctl.push = idle_found;
            end
            S_A_FIN:
            begin
                qctl.remove = full_reg;
            end
            S_F_CHK:
            begin
                qctl.push  = !free_bad && (32'(used_sel) >= 32'(spb_reg));
                q_push_val = BW'(fblk_reg);
            end
            S_F_REL:
            begin
                qctl.remove = 1'b1;
                q_key       = BW'(fblk_reg);
            end
            default:
            begin
            end
        endcase
    end

    sas_queue #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .INIT_LEN   (R_MINB)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (qctl),
        .key      (q_key),
        .push_val (q_push_val),
        .init_len (q_init_len),
        .head     (q_head),
        .len      (q_len)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            spb_reg        <= SPB_W'(R_SPB);
            minb_reg       <= MINB_W'(R_MINB);
            for (int i = 0; i < MAX_BLOCKS; i++)
            begin
                live_reg[i] <= (i < R_MINB);
                used_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
            live_cnt_reg   <= LW'(R_MINB);
            free_reg       <= FW'(R_MINB * R_SPB);
            fblk_reg       <= '0;
            fslot_reg      <= '0;
            u_reg          <= '0;
            byp_reg        <= 1'b0;
            full_reg       <= 1'b0;
            res_status_reg <= ST_OK;
            res_blk_reg    <= '0;
            res_slot_reg   <= '0;
            res_rel_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_OK;
            out_blk_reg    <= '0;
            out_slot_reg   <= '0;
            out_rel_reg    <= 1'b0;
            out_ftot_reg   <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && (state_reg != S_OUT))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (qctl.init)
                    begin
                        spb_reg  <= spb_new;
                        minb_reg <= minb_new;
                        for (int i = 0; i < MAX_BLOCKS; i++)
                        begin
                            live_reg[i] <= (i < 32'(minb_new));
                            used_reg[i] <= '0;
                            fill_reg[i] <= '0;
                        end
                        live_cnt_reg <= LW'(minb_new);
                        free_reg     <= FW'(32'(minb_new) * 32'(spb_new));
                    end
                    else if (in_fire)
                    begin
                        fblk_reg       <= free_block;
                        fslot_reg      <= free_slot;
                        res_status_reg <= ST_OK;
                        res_blk_reg    <= '0;
                        res_slot_reg   <= '0;
                        res_rel_reg    <= 1'b0;
                        if (mode == MODE_FREE)
                        begin
                            state_reg <= S_F_CHK;
                        end
                        else if (q_len == '0)
                        begin
                            state_reg <= S_A_GROW;
                        end
                        else
                        begin
                            state_reg <= S_A_TAKE;
                        end
                    end
                end
                S_A_GROW:
                begin
                    if (idle_found)
                    begin
                        live_reg[idle_blk] <= 1'b1;
                        used_reg[idle_blk] <= '0;
                        fill_reg[idle_blk] <= '0;
                        live_cnt_reg       <= live_cnt_reg + LW'(1);
                        free_reg           <= free_reg + FW'(spb_reg);
                        state_reg          <= S_A_TAKE;
                    end
                    else
                    begin
                        res_status_reg <= ST_EXHAUSTED;
                        state_reg      <= S_OUT;
                    end
                end
                S_A_TAKE:
                begin
                    res_blk_reg <= q_head;
                    u_reg       <= SW'(u_take);
                    byp_reg     <= (u_take == fill_sel);
                    if (u_take == fill_sel)
                    begin
                        fill_reg[q_head] <= fill_sel + CW'(1);
                    end
                    used_reg[q_head] <= u_take + CW'(1);
                    if (free_reg != '0)
                    begin
                        free_reg <= free_reg - FW'(1);
                    end
                    full_reg  <= (32'(u_take) + 32'd1) >= 32'(spb_reg);
                    state_reg <= S_A_FIN;
                end
                S_A_FIN:
                begin
                    res_slot_reg <= byp_reg ? u_reg : rd_q;
                    state_reg    <= S_OUT;
                end
                S_F_CHK:
                begin
                    if (free_bad)
                    begin
                        res_status_reg <= ST_BAD;
                        state_reg      <= S_OUT;
                    end
                    else
                    begin
                        free_reg          <= free_inc;
                        used_reg[blk_sel] <= used_dec;
                        state_reg         <= rel_cond ? S_F_REL : S_OUT;
                    end
                end
                S_F_REL:
                begin
                    live_reg[blk_sel] <= 1'b0;
                    fill_reg[blk_sel] <= '0;
                    live_cnt_reg      <= live_cnt_reg - LW'(1);
                    free_reg          <= free_reg - FW'(spb_reg);
                    res_rel_reg       <= 1'b1;
                    state_reg         <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= res_status_reg;
                        out_blk_reg    <= FBLK_W'(res_blk_reg);
                        out_slot_reg   <= FSLOT_W'(res_slot_reg);
                        out_rel_reg    <= res_rel_reg;
                        out_ftot_reg   <= FTOT_W'(free_reg);
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
